// ----- design/sccq_pkg.sv -----
// Package for the scan code key event queue: request, response and packet
// types, operation codes, special key codes and the set 1 key maps.
// No dependencies.
package sccq_pkg;

   localparam int QueueDepthDefault = 128;
   localparam int MapEntries = 84;

   localparam logic OpScan = 1'b0;
   localparam logic OpFetch = 1'b1;

   localparam logic [7:0] SkEsc = 8'hFF;
   localparam logic [7:0] SkBksp = 8'hFE;
   localparam logic [7:0] SkLCtrl = 8'hFD;
   localparam logic [7:0] SkLShift = 8'hFC;
   localparam logic [7:0] SkRShift = 8'hFB;
   localparam logic [7:0] SkLAlt = 8'hFA;
   localparam logic [7:0] SkCaps = 8'hF9;

   localparam logic [7:0] ReleaseFirst = 8'h81;
   localparam logic [7:0] ReleaseLast = 8'hD7;
   localparam logic [7:0] CaseBit = 8'h20;

   typedef struct packed {
      logic       operation;
      logic [7:0] scan_code;
   } req_type;

   typedef struct packed {
      logic              queue_empty;
      logic signed [7:0] key_value;
      logic              is_printable;
      logic              shift_flag;
      logic              alt_flag;
      logic              ctrl_flag;
      logic              caps_flag;
   } rsp_type;

   typedef struct packed {
      logic       caps;
      logic       ctrl;
      logic       alt;
      logic       shift;
      logic       printable;
      logic [7:0] value;
   } pkt_type;

   typedef struct packed {
      logic push;
      logic pop;
   } qctl_type;

   localparam logic [7:0] KeyPlain [0:MapEntries-1] = '{
      8'h00, SkEsc, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h30, 8'h2D, 8'h3D, SkBksp, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
      8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, SkLCtrl,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, SkLShift, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
      8'h6D, 8'h2C, 8'h2E, 8'h2F, SkRShift, 8'h2A, SkLAlt, 8'h20, SkCaps, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E
   };

   localparam logic [7:0] KeyShift [0:MapEntries-1] = '{
      8'h00, SkEsc, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
      8'h28, 8'h29, 8'h5F, 8'h2B, SkBksp, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
      8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, SkLCtrl,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, SkLShift, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
      8'h4D, 8'h3C, 8'h3E, 8'h3F, SkRShift, 8'h2A, SkLAlt, 8'h20, SkCaps, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E
   };

   // Caps lock inverts the case of letters in either map.
   function automatic logic [7:0] key_lookup(logic [6:0] idx, logic shift, logic caps);
      logic [7:0] v;
      if (idx >= 7'(MapEntries)) begin
         v = 8'h00;
      end else if (shift) begin
         v = KeyShift[idx];
      end else begin
         v = KeyPlain[idx];
      end
      if (caps && (v inside {[8'h41:8'h5A], [8'h61:8'h7A]})) begin
         v = v ^ CaseBit;
      end
      return v;
   endfunction

endpackage

// ----- design/sccq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sccq_ram #(
   parameter int Width = 13,
   parameter int Depth = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/sccq_queue.sv -----
// Key packet ring buffer: pointers, packet RAM, read stage and response register.
// Depends on sccq_pkg and sccq_ram.
module sccq_queue #(
   parameter int QueueDepth = sccq_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  sccq_pkg::qctl_type ctl,
   input  sccq_pkg::pkt_type push_data,
   output logic              busy,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sccq_pkg::rsp_type rsp_payload
);

   localparam int AddrWidth = $clog2(QueueDepth);
   localparam int CountWidth = $clog2(QueueDepth + 1);

   logic [AddrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [AddrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  stage_valid_ff, stage_valid_in;
   logic                  stage_empty_ff, stage_empty_in;
   logic                  out_valid_ff, out_valid_in;
   sccq_pkg::rsp_type     out_ff, out_in;
   sccq_pkg::pkt_type     rd_pkt;
   logic                  full;
   logic                  empty;
   logic                  pop_hit;
   logic                  advance;

   function automatic logic [AddrWidth-1:0] next_ptr(logic [AddrWidth-1:0] p);
      return (p == AddrWidth'(QueueDepth - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full = (count_ff == CountWidth'(QueueDepth));
   assign empty = (count_ff == '0);
   assign pop_hit = ctl.pop && !empty;
   assign advance = stage_valid_ff && (!out_valid_ff || !rsp_stall);
   assign busy = stage_valid_ff && !advance;

   sccq_ram #(
      .Width($bits(sccq_pkg::pkt_type)),
      .Depth(QueueDepth)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ctl.push),
      .wr_addr(wr_ptr_ff),
      .wr_data(push_data),
      .rd_en  (pop_hit),
      .rd_addr(rd_ptr_ff),
      .rd_data(rd_pkt)
   );

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in = count_ff;
      if (ctl.push) begin
         wr_ptr_in = next_ptr(wr_ptr_ff);
         if (full) begin
            rd_ptr_in = next_ptr(rd_ptr_ff);
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else if (pop_hit) begin
         rd_ptr_in = next_ptr(rd_ptr_ff);
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_empty_in = stage_empty_ff;
      if (ctl.pop) begin
         stage_valid_in = 1'b1;
         stage_empty_in = empty;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         if (stage_empty_ff) begin
            out_in = '0;
            out_in.queue_empty = 1'b1;
         end else begin
            out_in.queue_empty = 1'b0;
            out_in.key_value = rd_pkt.value;
            out_in.is_printable = rd_pkt.printable;
            out_in.shift_flag = rd_pkt.shift;
            out_in.alt_flag = rd_pkt.alt;
            out_in.ctrl_flag = rd_pkt.ctrl;
            out_in.caps_flag = rd_pkt.caps;
         end
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff <= '0;
         stage_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff <= count_in;
         stage_valid_ff <= stage_valid_in;
         out_valid_ff <= out_valid_in;
      end
      stage_empty_ff <= stage_empty_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(QueueDepth))
      else $error("packet count exceeds queue depth");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !advance) |=> (stage_valid_ff && $stable(rd_pkt)))
      else $error("held read stage lost its data");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (ctl.push && !full) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push into non-full queue did not grow the count");
`endif

endmodule

// ----- design/scan_code_key_event_queue_unit.sv -----
// Scan code set 1 key event queue, top level: modifier state and key map
// lookup in front of the packet ring buffer.
// Depends on sccq_pkg and sccq_queue.
// A fetch request's response passes through the read stage and then the response register.
// Throughput: one request per cycle; requests stall only while the read stage
// holds a response behind a stalled response register.
// Reset clears the modifiers, queue pointers and valid flags; packet RAM contents
// are not cleared and need no clearing pass.
module scan_code_key_event_queue_unit #(
   parameter int QueueDepth = sccq_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sccq_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sccq_pkg::rsp_type rsp_payload
);

   logic              shift_ff, shift_in;
   logic              alt_ff, alt_in;
   logic              ctrl_ff, ctrl_in;
   logic              caps_ff, caps_in;
   logic              accept;
   logic              is_press;
   logic              is_release;
   logic              hit;
   logic [7:0]        key;
   logic              busy;
   sccq_pkg::qctl_type ctl;
   sccq_pkg::pkt_type pkt;

   assign accept = req_valid && !req_stall;
   assign req_stall = busy;

   assign key = sccq_pkg::key_lookup(req_payload.scan_code[6:0], shift_ff, caps_ff);
   assign hit = (key != 8'h00);
   assign is_press = !req_payload.scan_code[7];
   assign is_release = req_payload.scan_code inside
      {[sccq_pkg::ReleaseFirst:sccq_pkg::ReleaseLast]};

   always_comb begin
      shift_in = shift_ff;
      alt_in = alt_ff;
      ctrl_in = ctrl_ff;
      caps_in = caps_ff;
      if (accept && (req_payload.operation == sccq_pkg::OpScan) && hit) begin
         if (is_press) begin
            if (key == sccq_pkg::SkLShift || key == sccq_pkg::SkRShift) begin
               shift_in = 1'b1;
            end
            if (key == sccq_pkg::SkLAlt) begin
               alt_in = 1'b1;
            end
            if (key == sccq_pkg::SkLCtrl) begin
               ctrl_in = 1'b1;
            end
            if (key == sccq_pkg::SkCaps) begin
               caps_in = !caps_ff;
            end
         end else if (is_release) begin
            if (key == sccq_pkg::SkLShift || key == sccq_pkg::SkRShift) begin
               shift_in = 1'b0;
            end
            if (key == sccq_pkg::SkLAlt) begin
               alt_in = 1'b0;
            end
            if (key == sccq_pkg::SkLCtrl) begin
               ctrl_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      pkt.value = key;
      pkt.printable = !key[7];
      pkt.shift = shift_in;
      pkt.alt = alt_in;
      pkt.ctrl = ctrl_in;
      pkt.caps = caps_in;
      ctl.push = accept && (req_payload.operation == sccq_pkg::OpScan) && is_press && hit;
      ctl.pop = accept && (req_payload.operation == sccq_pkg::OpFetch);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         alt_ff <= 1'b0;
         ctrl_ff <= 1'b0;
         caps_ff <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         alt_ff <= alt_in;
         ctrl_ff <= ctrl_in;
         caps_ff <= caps_in;
      end
   end

   sccq_queue #(
      .QueueDepth(QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .push_data  (pkt),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule
